>>> rtl/slbs_pkg.sv
// Shared types, codes and helpers of the status LED blink sequencer.
package slbs_pkg;

	localparam int TIMER_W = 16;
	localparam int CFG_W   = 16;
	localparam int LIMIT_W = 8;
	localparam int CMP_W   = (TIMER_W > CFG_W) ? TIMER_W : CFG_W;

	localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_LINK = 2'd1,
		CMD_POS  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		LINK_UNREG  = 2'd0,
		LINK_REG    = 2'd1,
		LINK_ACTIVE = 2'd2,
		LINK_PACKET = 2'd3
	} link_mode_t;

	typedef enum logic [1:0] {
		POS_VALID   = 2'd0,
		POS_FIXED   = 2'd1,
		POS_FLOAT   = 2'd2,
		POS_INVALID = 2'd3
	} pos_mode_t;

	typedef enum logic [2:0] {
		CFG_REG_ON        = 3'd0,
		CFG_REG_OFF       = 3'd1,
		CFG_ACTIVE_TOGGLE = 3'd2,
		CFG_PACKET_TOGGLE = 3'd3,
		CFG_PACKET_LIMIT  = 3'd4,
		CFG_POS_VALID     = 3'd5,
		CFG_POS_FIXED     = 3'd6,
		CFG_POS_FLOAT     = 3'd7
	} cfg_index_t;

	typedef struct packed {
		logic [CFG_W-1:0]   reg_on_ms;
		logic [CFG_W-1:0]   reg_off_ms;
		logic [CFG_W-1:0]   active_toggle_ms;
		logic [CFG_W-1:0]   packet_toggle_ms;
		logic [LIMIT_W-1:0] packet_toggle_limit;
		logic [CFG_W-1:0]   pos_valid_ms;
		logic [CFG_W-1:0]   pos_fixed_ms;
		logic [CFG_W-1:0]   pos_float_ms;
	} slbs_cfg_t;

	typedef struct packed {
		logic [1:0] command;
		logic [1:0] mode_value;
	} slbs_item_t;

	typedef struct packed {
		logic       link_led;
		logic       position_led;
		logic       power_led;
		link_mode_t link_mode_now;
		pos_mode_t  position_mode_now;
		logic       packet_blinking;
	} slbs_result_t;

	// Saturating advance of an elapsed timer
	function automatic logic [TIMER_W-1:0] timer_advance(input logic [TIMER_W-1:0] t);
		timer_advance = (t == TIMER_MAX) ? TIMER_MAX : t + 1'b1;
	endfunction

	// Interval has passed once elapsed reaches it
	function automatic logic interval_passed(input logic [TIMER_W-1:0] elapsed,
			input logic [CFG_W-1:0] interval);
		interval_passed = CMP_W'(elapsed) >= CMP_W'(interval);
	endfunction

endpackage

>>> rtl/slbs_cmd_if.sv
// Command channel: one tick or mode change per item.
interface slbs_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [1:0] mode_value;

	modport source (output valid, output command, output mode_value, input ready);
	modport sink (input valid, input command, input mode_value, output ready);
endinterface

>>> rtl/slbs_led_if.sv
// LED channel: LED drives and current modes, one item per command.
interface slbs_led_if;
	logic       valid;
	logic       ready;
	logic       link_led;
	logic       position_led;
	logic       power_led;
	logic [1:0] link_mode_now;
	logic [1:0] position_mode_now;
	logic       packet_blinking;

	modport source (output valid, output link_led, output position_led, output power_led,
		output link_mode_now, output position_mode_now, output packet_blinking,
		input ready);
	modport sink (input valid, input link_led, input position_led, input power_led,
		input link_mode_now, input position_mode_now, input packet_blinking,
		output ready);
endinterface

>>> rtl/slbs_cfg_regs.sv
// Configuration register file of the blink sequencer.
module slbs_cfg_regs (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [2:0]               index,
	input  logic [slbs_pkg::CFG_W-1:0] wdata,
	output slbs_pkg::slbs_cfg_t      cfg
);
	import slbs_pkg::*;

	slbs_cfg_t cfg_q;

	// Write the addressed register, load defaults on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reg_on_ms           <= CFG_W'(100);
			cfg_q.reg_off_ms          <= CFG_W'(1000);
			cfg_q.active_toggle_ms    <= CFG_W'(1000);
			cfg_q.packet_toggle_ms    <= CFG_W'(200);
			cfg_q.packet_toggle_limit <= LIMIT_W'(15);
			cfg_q.pos_valid_ms        <= CFG_W'(2000);
			cfg_q.pos_fixed_ms        <= CFG_W'(100);
			cfg_q.pos_float_ms        <= CFG_W'(500);
		end else if (we) begin
			unique case (cfg_index_t'(index))
				CFG_REG_ON:        cfg_q.reg_on_ms           <= wdata;
				CFG_REG_OFF:       cfg_q.reg_off_ms          <= wdata;
				CFG_ACTIVE_TOGGLE: cfg_q.active_toggle_ms    <= wdata;
				CFG_PACKET_TOGGLE: cfg_q.packet_toggle_ms    <= wdata;
				CFG_PACKET_LIMIT:  cfg_q.packet_toggle_limit <= wdata[LIMIT_W-1:0];
				CFG_POS_VALID:     cfg_q.pos_valid_ms        <= wdata;
				CFG_POS_FIXED:     cfg_q.pos_fixed_ms        <= wdata;
				CFG_POS_FLOAT:     cfg_q.pos_float_ms        <= wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

>>> rtl/slbs_core.sv
// LED state registers and the per-item update logic.
module slbs_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  slbs_pkg::slbs_item_t   item,
	input  slbs_pkg::slbs_cfg_t    cfg,
	output slbs_pkg::slbs_result_t result
);
	import slbs_pkg::*;

	link_mode_t           link_mode_q, link_mode_n;
	pos_mode_t            pos_mode_q, pos_mode_n;
	logic [TIMER_W-1:0]   link_el_q, link_el_n, link_adv;
	logic [TIMER_W-1:0]   pos_el_q, pos_el_n, pos_adv;
	logic                 link_pin_q, link_pin_n;
	logic                 link_mark_q, link_mark_n;
	logic                 pos_pin_q, pos_pin_n;
	logic                 pos_mark_q, pos_mark_n;
	logic                 pwr_pin_q, pwr_pin_n;
	logic                 pwr_mark_q, pwr_mark_n;
	logic                 phase_q, phase_n;
	logic                 pkt_q, pkt_n;
	logic [LIMIT_W-1:0]   pkt_cnt_q, pkt_cnt_n;
	logic [CFG_W-1:0]     pos_period;

	assign link_adv = timer_advance(link_el_q);
	assign pos_adv  = timer_advance(pos_el_q);

	// Pick the position toggle period
	always_comb begin
		case (pos_mode_q)
			POS_VALID: pos_period = cfg.pos_valid_ms;
			POS_FIXED: pos_period = cfg.pos_fixed_ms;
			default:   pos_period = cfg.pos_float_ms;
		endcase
	end

	// Work out the state after this item
	always_comb begin
		link_mode_n = link_mode_q;
		pos_mode_n  = pos_mode_q;
		link_el_n   = link_el_q;
		pos_el_n    = pos_el_q;
		link_pin_n  = link_pin_q;
		link_mark_n = link_mark_q;
		pos_pin_n   = pos_pin_q;
		pos_mark_n  = pos_mark_q;
		pwr_pin_n   = pwr_pin_q;
		pwr_mark_n  = pwr_mark_q;
		phase_n     = phase_q;
		pkt_n       = pkt_q;
		pkt_cnt_n   = pkt_cnt_q;

		unique case (item.command)
			CMD_TICK: begin
				link_el_n = link_adv;
				pos_el_n  = pos_adv;

				// Link LED
				unique case (link_mode_q)
					LINK_UNREG: link_pin_n = 1'b1;
					LINK_REG: begin
						if (!phase_q) begin
							link_pin_n = 1'b1;
							if (interval_passed(link_adv, cfg.reg_on_ms)) begin
								phase_n   = 1'b1;
								link_el_n = '0;
							end
						end else begin
							link_pin_n = 1'b0;
							if (interval_passed(link_adv, cfg.reg_off_ms)) begin
								phase_n   = 1'b0;
								link_el_n = '0;
							end
						end
					end
					LINK_ACTIVE: begin
						if (interval_passed(link_adv, cfg.active_toggle_ms)) begin
							link_pin_n  = ~link_mark_q;
							link_mark_n = ~link_mark_q;
							link_el_n   = '0;
						end
					end
					LINK_PACKET: begin
						pkt_n = 1'b1;
						if (interval_passed(link_adv, cfg.packet_toggle_ms)) begin
							if (pkt_cnt_q <= cfg.packet_toggle_limit) begin
								pkt_cnt_n   = pkt_cnt_q + 1'b1;
								link_pin_n  = ~link_mark_q;
								link_mark_n = ~link_mark_q;
								pwr_pin_n   = ~pwr_mark_q;
								pwr_mark_n  = ~pwr_mark_q;
								link_el_n   = '0;
							end else begin
								// Sequence done: drop back to active mode
								pkt_cnt_n   = '0;
								pkt_n       = 1'b0;
								link_mode_n = LINK_ACTIVE;
								link_el_n   = '0;
								pwr_pin_n   = 1'b0;
							end
						end
					end
					default: ;
				endcase

				// Position LED
				if (pos_mode_q == POS_INVALID) begin
					pos_pin_n = 1'b1;
				end else if (interval_passed(pos_adv, pos_period)) begin
					pos_pin_n  = ~pos_mark_q;
					pos_mark_n = ~pos_mark_q;
					pos_el_n   = '0;
				end
			end
			CMD_LINK: begin
				// During a packet blink only restart the timer
				if (pkt_q) begin
					link_el_n = '0;
				end else if (item.mode_value != link_mode_q) begin
					link_mode_n = link_mode_t'(item.mode_value);
					link_el_n   = '0;
				end
			end
			CMD_POS: begin
				if (item.mode_value != pos_mode_q) begin
					pos_mode_n = pos_mode_t'(item.mode_value);
					pos_el_n   = '0;
				end
			end
			default: ;
		endcase
	end

	// Hold state, advance on each processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_mode_q <= LINK_UNREG;
			pos_mode_q  <= POS_INVALID;
			link_el_q   <= '0;
			pos_el_q    <= '0;
			link_pin_q  <= 1'b0;
			link_mark_q <= 1'b0;
			pos_pin_q   <= 1'b0;
			pos_mark_q  <= 1'b0;
			pwr_pin_q   <= 1'b0;
			pwr_mark_q  <= 1'b0;
			phase_q     <= 1'b0;
			pkt_q       <= 1'b0;
			pkt_cnt_q   <= '0;
		end else if (step) begin
			link_mode_q <= link_mode_n;
			pos_mode_q  <= pos_mode_n;
			link_el_q   <= link_el_n;
			pos_el_q    <= pos_el_n;
			link_pin_q  <= link_pin_n;
			link_mark_q <= link_mark_n;
			pos_pin_q   <= pos_pin_n;
			pos_mark_q  <= pos_mark_n;
			pwr_pin_q   <= pwr_pin_n;
			pwr_mark_q  <= pwr_mark_n;
			phase_q     <= phase_n;
			pkt_q       <= pkt_n;
			pkt_cnt_q   <= pkt_cnt_n;
		end
	end

	// Result shows the state after the item
	always_comb begin
		result.link_led          = link_pin_n;
		result.position_led      = pos_pin_n;
		result.power_led         = pwr_pin_n;
		result.link_mode_now     = link_mode_n;
		result.position_mode_now = pos_mode_n;
		result.packet_blinking   = pkt_n;
	end
endmodule

>>> rtl/status_led_blink_sequencer.sv
// Top level of the status LED blink sequencer.
//
// Usage:
//  cmd_ch carries one item per handshake: a millisecond tick (command 0), a link
//  mode change (command 1) or a position mode change (command 2) with mode_value.
//  led_ch returns exactly one item per command item: the link, position and power
//  LED drives, the current link and position modes and the packet-blink flag,
//  all as they stand after that command.
//  The configuration port (cfg_we, cfg_index, cfg_wdata) writes one of eight
//  interval/limit registers per cycle; write it only while no item is in flight.
// Pipeline and throughput:
//  An item is registered in the input register on acceptance, and its result is
//  registered in the result register once that register is free or being read.
//  One item is taken per cycle while led_ch does not stall; the state update
//  is a single pass of compare and increment logic.
// Reset and stall:
//  arst_n clears the LED state, link mode to unregistered, position mode to
//  invalid, and loads the register defaults. When led_ch stalls the result is
//  held and one more item is taken into the input register; cmd_ch ready then
//  drops until the result is taken.
module status_led_blink_sequencer (
	input  logic                      clk,
	input  logic                      arst_n,
	slbs_cmd_if.sink                  cmd_ch,
	slbs_led_if.source                led_ch,
	input  logic                      cfg_we,
	input  logic [2:0]                cfg_index,
	input  logic [slbs_pkg::CFG_W-1:0] cfg_wdata
);
	import slbs_pkg::*;

	slbs_cfg_t    cfg;
	slbs_item_t   item_s1;
	logic         valid_s1;
	logic         adv;
	logic         take;
	slbs_result_t result;
	slbs_result_t result_q;
	logic         led_valid_q;

	slbs_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	// Process the held item once the result register is free
	assign adv          = valid_s1 && (!led_valid_q || led_ch.ready);
	assign cmd_ch.ready = !valid_s1 || adv;
	assign take         = cmd_ch.valid && cmd_ch.ready;

	slbs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ch.ready) begin
			valid_s1 <= cmd_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.command    <= cmd_ch.command;
			item_s1.mode_value <= cmd_ch.mode_value;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_valid_q <= 1'b0;
		end else if (adv) begin
			led_valid_q <= 1'b1;
		end else if (led_ch.ready) begin
			led_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= result;
		end
	end

	assign led_ch.valid             = led_valid_q;
	assign led_ch.link_led          = result_q.link_led;
	assign led_ch.position_led      = result_q.position_led;
	assign led_ch.power_led         = result_q.power_led;
	assign led_ch.link_mode_now     = result_q.link_mode_now;
	assign led_ch.position_mode_now = result_q.position_mode_now;
	assign led_ch.packet_blinking   = result_q.packet_blinking;

`ifndef SYNTHESIS
	// Packet blink only runs in packet-success link mode
	a_pkt_mode: assert property (@(posedge clk) disable iff (!arst_n)
		led_ch.valid && led_ch.packet_blinking |-> led_ch.link_mode_now == LINK_PACKET)
		else $error("packet blink outside packet link mode");

	// Ready only drops with both stages full
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ch.ready |-> valid_s1 && led_valid_q)
		else $error("input stalled with a free stage");

	// A processed item shows up as a result next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> led_ch.valid)
		else $error("processed item produced no result");
`endif
endmodule
